// ----- src/wtp_pkg.sv -----
package wtp_pkg;

   localparam int CMD_W      = 2;
   localparam int DIST_IDX_W = 2;
   localparam int TILE_IDX_W = 6;
   localparam int WIN_W      = 16;
   localparam int MASK_W     = 64;
   localparam int ACT_W      = 4;
   localparam int RAND_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 4;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_REGS   = 4;
   localparam int MAX_DISTS  = 4;
   localparam int BYTE_TILES = 8;
   localparam int LANE_W     = 3;
   localparam int DCNT_W     = 3;
   localparam int JCNT_W     = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_PICK  = 2'd1,
      CMD_UNION = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PICKED = 2'd0,
      ST_NONE   = 2'd1,
      ST_DONE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_WR,
      S_SCAN,
      S_ACC,
      S_DIV_ROLL,
      S_DIV_TILE,
      S_LANE
   } state_type;

endpackage

// ----- src/wtp_ram.sv -----
module wtp_ram #(
   parameter int W = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/wtp_div.sv -----
module wtp_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] remainder
);

   localparam int CW = $clog2(W + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    trial;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[W-1]};
      if (start) begin
         cnt_in = CW'(W);
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (cnt_ff != '0) begin
         // One restoring step: shift in a dividend bit, subtract when it fits.
         num_in = {num_ff[W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/weighted_tile_picker.sv -----
// Weighted tile picker: keeps per-tile weights for up to four distributions
// and draws one tile by roulette-wheel selection.
// An item is accepted at a clock edge where start is high and busy is low.
// Every item gives exactly one result, shown on the rsp_ ports for a single
// cycle while rsp_valid is high; the receiver cannot hold it off.
// A union, an ignored add or an unknown command is answered in the next
// cycle; a valid add reads its weight row when taken, then merges the new
// weight into its lane and writes the row back. A pick scans the rows of
// the active distributions twice, through a scan and an accumulate state
// per row, runs one 32-step remainder for the byte draw and, when
// weighted, a second one for the draw inside the byte, then walks up to
// eight tiles. The row scans and the one-bit-per-cycle remainder unit set
// how long a pick takes. A new item is taken in the cycle the result is
// shown.
// Reset clears the present masks, which also hide stale weight rows, and
// sets every span register to eight bytes; no clearing pass is needed.
// Span registers are written through csr_we, csr_index and csr_data; the user
// must write them only while the block is idle, which the block does not enforce.
module weighted_tile_picker #(
   parameter int DISTS = 4,
   parameter int TILES = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [wtp_pkg::CMD_W-1:0]        req_cmd,
   input  logic [wtp_pkg::DIST_IDX_W-1:0]   req_dist_index,
   input  logic [wtp_pkg::TILE_IDX_W-1:0]   req_tile_index,
   input  logic [wtp_pkg::WIN_W-1:0]        req_tile_weight,
   input  logic [wtp_pkg::MASK_W-1:0]       req_candidate_mask,
   input  logic [wtp_pkg::ACT_W-1:0]        req_active_set,
   input  logic [wtp_pkg::RAND_W-1:0]       req_random_a,
   input  logic [wtp_pkg::RAND_W-1:0]       req_random_b,
   output logic                             rsp_valid,
   output logic [wtp_pkg::TILE_IDX_W-1:0]   rsp_picked_tile,
   output logic [wtp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [wtp_pkg::MASK_W-1:0]       rsp_union_mask,
   input  logic                             csr_we,
   input  logic [wtp_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [wtp_pkg::CFG_W-1:0]        csr_data
);
   import wtp_pkg::*;

   localparam int NBYTES = (TILES + BYTE_TILES - 1) / BYTE_TILES;
   localparam int ROWS   = DISTS * NBYTES;
   localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RW     = BYTE_TILES * WEIGHT_BITS;
   localparam int TW     = WEIGHT_BITS + $clog2(ROWS * BYTE_TILES + 1);
   localparam int DW     = (TW > RAND_W) ? TW : RAND_W;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]       cfg_ff [CFG_REGS];
   logic [MASK_W-1:0]      present_ff [MAX_DISTS];
   logic [MASK_W-1:0]      present_in [MAX_DISTS];

   logic [DCNT_W-1:0]      d_ff, d_in;
   logic [JCNT_W-1:0]      j_ff, j_in;
   logic [LANE_W-1:0]      k_ff, k_in;
   logic                   pass2_ff, pass2_in;
   logic                   uni_ff, uni_in;
   logic [DW-1:0]          total_ff, total_in;
   logic [DW-1:0]          count_ff, count_in;
   logic [DW-1:0]          run_ff, run_in;
   logic [DW-1:0]          roll_ff, roll_in;
   logic [DW-1:0]          r2_ff, r2_in;
   logic [DW-1:0]          acc_ff, acc_in;
   logic [WEIGHT_BITS-1:0] lane_ff [BYTE_TILES];
   logic [WEIGHT_BITS-1:0] lane_in [BYTE_TILES];
   logic [2:0]             hit_j_ff, hit_j_in;

   logic [MASK_W-1:0]      cand_ff, cand_in;
   logic [ACT_W-1:0]       act_ff, act_in;
   logic [RAND_W-1:0]      ra_ff, ra_in;
   logic [RAND_W-1:0]      rb_ff, rb_in;
   logic [AW-1:0]          add_row_ff, add_row_in;
   logic [LANE_W-1:0]      add_lane_ff, add_lane_in;
   logic [WEIGHT_BITS-1:0] add_w_ff, add_w_in;
   logic [1:0]             add_d_ff, add_d_in;
   logic [TILE_IDX_W-1:0]  add_t_ff, add_t_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TILE_IDX_W-1:0]  rsp_tile_ff, rsp_tile_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [MASK_W-1:0]      rsp_union_ff, rsp_union_in;

   // RAM and divider hookup
   logic                   ram_we;
   logic [AW-1:0]          ram_raddr;
   logic [RW-1:0]          ram_wdata;
   logic [RW-1:0]          ram_rdata;
   logic                   div_start;
   logic [DW-1:0]          div_a, div_b;
   logic                   div_done;
   logic [DW-1:0]          div_rem;

   // Combinational helpers
   logic [1:0]             dcur;
   logic [CFG_W-1:0]       span_cur;
   logic                   in_walk;
   logic [AW-1:0]          scan_addr;
   logic [WEIGHT_BITS-1:0] wv [BYTE_TILES];
   logic [WEIGHT_BITS-1:0] uv [BYTE_TILES];
   logic [DW-1:0]          bsum, pc, bval, run_next, lane_acc;
   logic [MASK_W-1:0]      union_val;
   logic                   add_ok;
   logic [AW-1:0]          req_row;

   function automatic logic [CFG_W-1:0] span_of(logic [CFG_W-1:0] n);
      return (n > CFG_W'(NBYTES)) ? CFG_W'(NBYTES) : n;
   endfunction

   function automatic logic [MASK_W-1:0] span_mask(logic [CFG_W-1:0] n);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int t = 0; t < MASK_W; t++) begin
         m[t] = ((t / BYTE_TILES) < int'(span_of(n))) && (t < TILES);
      end
      return m;
   endfunction

   wtp_ram #(.W(RW), .DEPTH(ROWS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (add_row_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wtp_div #(.W(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      dcur      = d_ff[1:0];
      span_cur  = span_of(cfg_ff[dcur]);
      in_walk   = (int'(d_ff) < DISTS) && act_ff[dcur] && ({1'b0, j_ff} < {1'b0, span_cur});
      scan_addr = AW'(int'(dcur) * NBYTES + int'(j_ff));
      add_ok    = (int'(req_dist_index) < DISTS) && (int'(req_tile_index) < TILES);
      req_row   = AW'(int'(req_dist_index) * NBYTES + int'(req_tile_index) / BYTE_TILES);

      // Lane values of the row just read. A tile never added to its
      // distribution reads as zero weight, whatever the row holds.
      bsum = '0;
      pc   = '0;
      for (int k = 0; k < BYTE_TILES; k++) begin
         logic [TILE_IDX_W-1:0] t;
         logic                  ok;
         t  = {j_ff[2:0], LANE_W'(k)};
         ok = (int'(t) < TILES) && cand_ff[t];
         wv[k] = (ok && present_ff[dcur][t]) ?
                 ram_rdata[k*WEIGHT_BITS +: WEIGHT_BITS] : '0;
         uv[k] = ok ? WEIGHT_BITS'(1) : '0;
         bsum  = bsum + DW'(wv[k]);
         pc    = pc + DW'(uv[k]);
      end
      bval     = uni_ff ? pc : bsum;
      run_next = run_ff + bval;
      lane_acc = acc_ff + DW'(lane_ff[k_ff]);

      union_val = '0;
      for (int d = 0; d < MAX_DISTS; d++) begin
         if (d < DISTS && req_active_set[d]) begin
            union_val = union_val | (present_ff[d] & span_mask(cfg_ff[d]));
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      present_in    = present_ff;
      d_in          = d_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      pass2_in      = pass2_ff;
      uni_in        = uni_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      roll_in       = roll_ff;
      r2_in         = r2_ff;
      acc_in        = acc_ff;
      lane_in       = lane_ff;
      hit_j_in      = hit_j_ff;
      cand_in       = cand_ff;
      act_in        = act_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      add_row_in    = add_row_ff;
      add_lane_in   = add_lane_ff;
      add_w_in      = add_w_ff;
      add_d_in      = add_d_ff;
      add_t_in      = add_t_ff;
      rsp_valid_in  = 1'b0;
      rsp_tile_in   = '0;
      rsp_status_in = ST_DONE;
      rsp_union_in  = '0;
      ram_we        = 1'b0;
      ram_raddr     = scan_addr;
      ram_wdata     = ram_rdata;
      div_start     = 1'b0;
      div_a         = DW'(ra_ff);
      div_b         = total_ff;

      unique case (state_ff)
         S_IDLE: begin
            ram_raddr = req_row;
            if (start) begin
               cand_in     = req_candidate_mask;
               act_in      = req_active_set;
               ra_in       = req_random_a;
               rb_in       = req_random_b;
               add_row_in  = req_row;
               add_lane_in = req_tile_index[LANE_W-1:0];
               add_w_in    = WEIGHT_BITS'(req_tile_weight);
               add_d_in    = req_dist_index;
               add_t_in    = req_tile_index;
               unique case (cmd_type'(req_cmd))
                  CMD_ADD: begin
                     if (add_ok) begin
                        state_in = S_ADD_WR;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_PICK: begin
                     d_in     = '0;
                     j_in     = '0;
                     total_in = '0;
                     count_in = '0;
                     pass2_in = 1'b0;
                     uni_in   = 1'b0;
                     state_in = S_SCAN;
                  end
                  CMD_UNION: begin
                     rsp_valid_in = 1'b1;
                     rsp_union_in = union_val;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ADD_WR: begin
            // The row read last cycle gets the new weight in its lane.
            ram_we = 1'b1;
            ram_wdata[int'(add_lane_ff)*WEIGHT_BITS +: WEIGHT_BITS] = add_w_ff;
            present_in[add_d_ff][add_t_ff] = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            if (int'(d_ff) >= DISTS) begin
               if (total_ff != '0) begin
                  div_start = 1'b1;
                  uni_in    = 1'b0;
                  state_in  = S_DIV_ROLL;
               end else if (count_ff != '0) begin
                  div_start = 1'b1;
                  div_b     = count_ff;
                  uni_in    = 1'b1;
                  state_in  = S_DIV_ROLL;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NONE;
                  state_in      = S_IDLE;
               end
            end else if (in_walk) begin
               state_in = S_ACC;
            end else begin
               d_in = d_ff + DCNT_W'(1);
               j_in = '0;
            end
         end
         S_ACC: begin
            if (!pass2_ff) begin
               total_in = total_ff + bsum;
               count_in = count_ff + pc;
               j_in     = j_ff + JCNT_W'(1);
               state_in = S_SCAN;
            end else if (run_next > roll_ff) begin
               for (int k = 0; k < BYTE_TILES; k++) begin
                  lane_in[k] = uni_ff ? uv[k] : wv[k];
               end
               hit_j_in = j_ff[2:0];
               acc_in   = '0;
               k_in     = '0;
               if (uni_ff) begin
                  // Uniform draw: the offset inside this byte is known already.
                  r2_in    = roll_ff - run_ff;
                  state_in = S_LANE;
               end else begin
                  div_start = 1'b1;
                  div_a     = DW'(rb_ff);
                  div_b     = bval;
                  state_in  = S_DIV_TILE;
               end
            end else begin
               run_in   = run_next;
               j_in     = j_ff + JCNT_W'(1);
               state_in = S_SCAN;
            end
         end
         S_DIV_ROLL: begin
            if (div_done) begin
               roll_in  = div_rem;
               d_in     = '0;
               j_in     = '0;
               run_in   = '0;
               pass2_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DIV_TILE: begin
            if (div_done) begin
               r2_in    = div_rem;
               state_in = S_LANE;
            end
         end
         S_LANE: begin
            if (lane_acc > r2_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_PICKED;
               rsp_tile_in   = {hit_j_ff, k_ff};
               state_in      = S_IDLE;
            end else begin
               acc_in = lane_acc;
               k_in   = k_ff + LANE_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CFG_REGS; i++) begin
            cfg_ff[i] <= CFG_RESET;
         end
         for (int i = 0; i < MAX_DISTS; i++) begin
            present_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         if (csr_we) begin
            cfg_ff[csr_index] <= csr_data;
         end
      end
      d_ff          <= d_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      pass2_ff      <= pass2_in;
      uni_ff        <= uni_in;
      total_ff      <= total_in;
      count_ff      <= count_in;
      run_ff        <= run_in;
      roll_ff       <= roll_in;
      r2_ff         <= r2_in;
      acc_ff        <= acc_in;
      lane_ff       <= lane_in;
      hit_j_ff      <= hit_j_in;
      cand_ff       <= cand_in;
      act_ff        <= act_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      add_row_ff    <= add_row_in;
      add_lane_ff   <= add_lane_in;
      add_w_ff      <= add_w_in;
      add_d_ff      <= add_d_in;
      add_t_ff      <= add_t_in;
      rsp_tile_ff   <= rsp_tile_in;
      rsp_status_ff <= rsp_status_in;
      rsp_union_ff  <= rsp_union_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_picked_tile = rsp_tile_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_union_mask  = rsp_union_ff;

   // A result is only shown once the item that caused it is finished.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while the block is still busy");

   // A result follows either an item taken in idle or the end of a longer item.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) != S_IDLE || $past(start)))
      else $error("result without a cause");

   // The tile walk always finds its tile within the chosen byte.
   a_lane_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LANE && k_ff == LANE_W'(BYTE_TILES - 1)) |-> (lane_acc > r2_ff))
      else $error("tile walk ran past the last tile of the byte");

   // A failed pick never names a tile.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NONE) |-> (rsp_picked_tile == '0))
      else $error("no-candidate result carries a tile");

   // Weight rows are written back only right after their read.
   a_rmw: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ($past(state_ff) == S_IDLE && $past(start)))
      else $error("weight row written without its read");

endmodule
